// ===== sv/vldr_pkg.sv =====
`timescale 1ns / 1ps
// vldr_pkg: shared types, widths and codes of the varint level range decoder
// no dependencies

package vldr_pkg;

	localparam int unsigned DATA_W   = 8;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned REM_W    = 31;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned EXP_W    = 4;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned PAYLOAD_W = 7;
	localparam int unsigned ACC_BYTES = 5;

	localparam int unsigned MAX_VARINT_BYTES_DEF = 5;
	localparam int unsigned MAX_EXPONENT_DEF     = 9;

	typedef enum logic [KIND_W-1:0] {
		KIND_RANGE = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef struct packed {
		logic [DATA_W-1:0] data_byte;
		logic              restart;
	} byte_item_t;

	typedef struct packed {
		kind_t                    item_kind;
		logic signed [VAL_W-1:0]  range_low;
		logic signed [VAL_W-1:0]  range_high;
		logic [EXP_W-1:0]         scale_exponent;
		logic                     record_last;
	} result_t;

endpackage

// ===== sv/vldr_if.sv =====
`timescale 1ns / 1ps
// vldr_if: byte and range channel interfaces, valid/ready handshake
// depends on vldr_pkg

interface vldr_byte_if;
	logic                        valid;
	logic                        ready;
	logic [vldr_pkg::DATA_W-1:0] data_byte;
	logic                        restart;

	modport source (output valid, output data_byte, output restart, input ready);
	modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface vldr_range_if;
	logic                              valid;
	logic                              ready;
	logic [vldr_pkg::KIND_W-1:0]       item_kind;
	logic signed [vldr_pkg::VAL_W-1:0] range_low;
	logic signed [vldr_pkg::VAL_W-1:0] range_high;
	logic [vldr_pkg::EXP_W-1:0]        scale_exponent;
	logic                              record_last;

	modport source (output valid, output item_kind, output range_low, output range_high,
		output scale_exponent, output record_last, input ready);
	modport sink   (input valid, input item_kind, input range_low, input range_high,
		input scale_exponent, input record_last, output ready);
endinterface

// ===== sv/vldr_in_reg.sv =====
`timescale 1ns / 1ps
// vldr_in_reg: input register stage for the byte channel
// depends on vldr_pkg and vldr_if

module vldr_in_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	vldr_byte_if.sink            byte_chan,
	input  logic                 advance,
	output logic                 item_valid,
	output vldr_pkg::byte_item_t item
);
	import vldr_pkg::*;

	logic       valid_s1;
	byte_item_t item_s1;

	assign byte_chan.ready = !valid_s1 || advance;
	assign item_valid      = valid_s1;
	assign item            = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_chan.ready) begin
			valid_s1 <= byte_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_chan.ready && byte_chan.valid) begin
			item_s1.data_byte <= byte_chan.data_byte;
			item_s1.restart   <= byte_chan.restart;
		end
	end

endmodule

// ===== sv/vldr_core.sv =====
`timescale 1ns / 1ps
// vldr_core: record parse state, varint assembly, zigzag decode and range tracking
// depends on vldr_pkg

module vldr_core #(
	parameter int unsigned MAX_VARINT_BYTES = vldr_pkg::MAX_VARINT_BYTES_DEF,
	parameter int unsigned MAX_EXPONENT     = vldr_pkg::MAX_EXPONENT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic signed [vldr_pkg::VAL_W-1:0] cfg_wdata,
	input  logic                             step,
	input  vldr_pkg::byte_item_t             item,
	output logic                             res_valid,
	output vldr_pkg::result_t                res
);
	import vldr_pkg::*;

	typedef enum logic [1:0] {
		PH_SIZE   = 2'd0,
		PH_EXP    = 2'd1,
		PH_LEVELS = 2'd2
	} phase_t;

	localparam int unsigned PART_W = PAYLOAD_W * ACC_BYTES + DATA_W - PAYLOAD_W - 1;

	logic [VAL_W-1:0] sep_q;
	phase_t           phase_q, phase_cur, phase_nxt;
	logic [VAL_W-1:0] acc_q, acc_cur, acc_new, acc_nxt;
	logic [IDX_W-1:0] idx_q, idx_cur, idx_inc, idx_nxt;
	logic [REM_W-1:0] rem_q, rem_cur, rem_dec, rem_nxt;
	logic [EXP_W-1:0] exp_q, exp_cur, exp_nxt;
	logic             open_q, open_cur, open_nxt;
	logic [VAL_W-1:0] lo_q, lo_cur, lo_nxt;
	logic [VAL_W-1:0] hi_q, hi_cur, hi_nxt;
	logic [PART_W-1:0] part;
	logic [VAL_W-1:0] val;
	logic             more, at_end, err, clr, check_end;

	always_comb begin
		if (item.restart) begin
			phase_cur = PH_SIZE;
			acc_cur   = '0;
			idx_cur   = '0;
			rem_cur   = '0;
			exp_cur   = '0;
			open_cur  = 1'b0;
			lo_cur    = '0;
			hi_cur    = '0;
		end else begin
			phase_cur = phase_q;
			acc_cur   = acc_q;
			idx_cur   = idx_q;
			rem_cur   = rem_q;
			exp_cur   = exp_q;
			open_cur  = open_q;
			lo_cur    = lo_q;
			hi_cur    = hi_q;
		end
	end

	// byte payload placed at its 7-bit group, bits past 32 dropped
	assign part    = PART_W'(item.data_byte[PAYLOAD_W-1:0]) << (6'(idx_cur) * 6'(PAYLOAD_W));
	assign acc_new = (idx_cur < IDX_W'(ACC_BYTES)) ? (acc_cur | part[VAL_W-1:0]) : acc_cur;
	assign idx_inc = idx_cur + IDX_W'(1);
	assign more    = item.data_byte[DATA_W-1];
	assign rem_dec = (phase_cur != PH_SIZE && rem_cur != '0) ? rem_cur - REM_W'(1) : rem_cur;
	assign at_end  = (phase_cur != PH_SIZE) && (rem_dec == '0);
	assign val     = {1'b0, acc_new[VAL_W-1:1]} ^ {VAL_W{acc_new[0]}};

	always_comb begin
		phase_nxt = phase_cur;
		acc_nxt   = acc_new;
		idx_nxt   = idx_inc;
		rem_nxt   = rem_dec;
		exp_nxt   = exp_cur;
		open_nxt  = open_cur;
		lo_nxt    = lo_cur;
		hi_nxt    = hi_cur;
		err       = 1'b0;
		clr       = 1'b0;
		check_end = 1'b0;
		res_valid = 1'b0;
		res       = '0;

		if (more) begin
			if (idx_inc >= IDX_W'(MAX_VARINT_BYTES) || at_end) begin
				err = 1'b1;
			end
		end else begin
			acc_nxt = '0;
			idx_nxt = '0;
			unique case (phase_cur)
				PH_SIZE: begin
					if (val == '0 || val[VAL_W-1]) begin
						err = 1'b1;
					end else begin
						rem_nxt   = val[REM_W-1:0];
						phase_nxt = PH_EXP;
					end
				end
				PH_EXP: begin
					if (!val[VAL_W-1] && val[VAL_W-2:0] > (VAL_W-1)'(MAX_EXPONENT)) begin
						err = 1'b1;
					end else begin
						exp_nxt   = val[VAL_W-1] ? '0 : val[EXP_W-1:0];
						phase_nxt = PH_LEVELS;
						check_end = 1'b1;
					end
				end
				default: begin
					if (val == sep_q) begin
						if (open_cur) begin
							res_valid       = 1'b1;
							res.item_kind   = KIND_RANGE;
							res.range_low   = lo_cur;
							res.range_high  = hi_cur;
							res.scale_exponent = exp_cur;
							res.record_last = at_end;
							open_nxt        = 1'b0;
							clr             = at_end;
						end else begin
							check_end = 1'b1;
						end
					end else if (!open_cur) begin
						lo_nxt    = val;
						hi_nxt    = val;
						open_nxt  = 1'b1;
						check_end = 1'b1;
					end else begin
						hi_nxt    = val;
						check_end = 1'b1;
					end
				end
			endcase

			if (check_end && at_end) begin
				res_valid          = 1'b1;
				res.item_kind      = open_nxt ? KIND_RANGE : KIND_EMPTY;
				res.range_low      = open_nxt ? lo_nxt : '0;
				res.range_high     = open_nxt ? hi_nxt : '0;
				res.scale_exponent = exp_nxt;
				res.record_last    = 1'b1;
				clr                = 1'b1;
			end
		end

		if (err) begin
			res_valid       = 1'b1;
			res             = '0;
			res.item_kind   = KIND_ERROR;
			res.record_last = 1'b1;
			clr             = 1'b1;
		end

		if (clr) begin
			phase_nxt = PH_SIZE;
			acc_nxt   = '0;
			idx_nxt   = '0;
			rem_nxt   = '0;
			exp_nxt   = '0;
			open_nxt  = 1'b0;
			lo_nxt    = '0;
			hi_nxt    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q   <= '0;
			phase_q <= PH_SIZE;
			acc_q   <= '0;
			idx_q   <= '0;
			rem_q   <= '0;
			exp_q   <= '0;
			open_q  <= 1'b0;
			lo_q    <= '0;
			hi_q    <= '0;
		end else begin
			if (cfg_we) begin
				sep_q <= cfg_wdata;
			end
			if (step) begin
				phase_q <= phase_nxt;
				acc_q   <= acc_nxt;
				idx_q   <= idx_nxt;
				rem_q   <= rem_nxt;
				exp_q   <= exp_nxt;
				open_q  <= open_nxt;
				lo_q    <= lo_nxt;
				hi_q    <= hi_nxt;
			end
		end
	end

endmodule

// ===== sv/vldr_out_reg.sv =====
`timescale 1ns / 1ps
// vldr_out_reg: result register driving the range channel
// depends on vldr_pkg and vldr_if

module vldr_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	vldr_range_if.source      range_chan,
	input  logic              item_valid,
	input  logic              res_valid,
	input  vldr_pkg::result_t res,
	output logic              advance
);
	import vldr_pkg::*;

	logic    valid_q;
	result_t res_q;
	logic    stall;

	assign stall   = valid_q && !range_chan.ready;
	assign advance = item_valid && !stall;

	assign range_chan.valid          = valid_q;
	assign range_chan.item_kind      = res_q.item_kind;
	assign range_chan.range_low      = res_q.range_low;
	assign range_chan.range_high     = res_q.range_high;
	assign range_chan.scale_exponent = res_q.scale_exponent;
	assign range_chan.record_last    = res_q.record_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!stall) begin
			valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

endmodule

// ===== sv/varint_level_range_decoder_unit.sv =====
`timescale 1ns / 1ps
// varint_level_range_decoder_unit: one byte per transfer in, at most one range item out
// depends on vldr_pkg, vldr_if, vldr_in_reg, vldr_core, vldr_out_reg
// path: byte transfer to input register, core logic, then result register
// throughput: one byte per cycle unless range_chan stalls; combinational state update
// reset: arst_n clears the separator, the parse state and both channel stages

module varint_level_range_decoder_unit #(
	parameter int unsigned MAX_VARINT_BYTES = vldr_pkg::MAX_VARINT_BYTES_DEF,
	parameter int unsigned MAX_EXPONENT     = vldr_pkg::MAX_EXPONENT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	vldr_byte_if.sink                         byte_chan,
	vldr_range_if.source                      range_chan,
	input  logic                              cfg_we,
	input  logic signed [vldr_pkg::VAL_W-1:0] cfg_wdata
);
	import vldr_pkg::*;

	logic       item_valid;
	byte_item_t item;
	logic       advance;
	logic       res_valid;
	result_t    res;

	vldr_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_chan  (byte_chan),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	vldr_core #(
		.MAX_VARINT_BYTES (MAX_VARINT_BYTES),
		.MAX_EXPONENT     (MAX_EXPONENT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (advance),
		.item      (item),
		.res_valid (res_valid),
		.res       (res)
	);

	vldr_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.range_chan (range_chan),
		.item_valid (item_valid),
		.res_valid  (res_valid),
		.res        (res),
		.advance    (advance)
	);

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		range_chan.valid && range_chan.item_kind == KIND_ERROR |->
		range_chan.range_low == '0 && range_chan.range_high == '0 &&
		range_chan.scale_exponent == '0 && range_chan.record_last)
		else $error("error item with nonzero fields");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		range_chan.valid && range_chan.item_kind == KIND_EMPTY |->
		range_chan.range_low == '0 && range_chan.range_high == '0 && range_chan.record_last)
		else $error("empty record end malformed");

	a_exp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		range_chan.valid |-> range_chan.scale_exponent <= EXP_W'(MAX_EXPONENT))
		else $error("scale exponent above bound");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && range_chan.valid && !range_chan.ready |-> !byte_chan.ready && !advance)
		else $error("byte taken while result stage stalled");

endmodule
